### sv/baro_pressure_temp_compensation_macros.svh
// ============================================================================
// Assertion macros for the barometric compensation block
// Concurrent property wrappers clocked on clk_i and disabled in reset.
// ============================================================================
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH

// same-cycle implication
`define BPTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bptc_pkg.sv
// ============================================================================
// bptc_pkg
// Types, widths and constants of the barometric compensation pipeline.
// ============================================================================
`default_nettype none

package bptc_pkg;

  // field widths
  localparam int RawW   = 24;
  localparam int CoefW  = 16;
  localparam int TempW  = 20;
  localparam int PresW  = 32;

  // APB
  localparam int DataW   = 32;
  localparam int AddrW   = 5;
  localparam int AddrLsb = 2;

  // internal widths
  localparam int DtW    = 25;            // raw temp minus reference
  localparam int CoefSW = CoefW + 1;     // coefficient as signed
  localparam int ProdW  = DtW + CoefSW;  // dT times coefficient
  localparam int DdW    = 2 * DtW;       // dT squared
  localparam int DevW   = 19;            // TEMP - 2000
  localparam int T2W    = 18;            // dT^2 >> 31
  localparam int SqW    = 35;            // squared deviations
  localparam int CorrW  = 39;            // OFF2 / SENS2
  localparam int OffW   = 42;            // OFF / SENS
  localparam int SplitW = 21;            // SENS split for the pressure product
  localparam int PpW    = DtW + SplitW;  // signed high partial product
  localparam int PplW   = RawW + SplitW; // unsigned low partial product
  localparam int SumW   = 48;
  localparam int PshW   = SumW - 15;

  // shifts of the compensation scheme
  localparam int TempSh     = 23;
  localparam int OffSh      = 7;
  localparam int SensSh     = 8;
  localparam int OffBaseSh  = 16;
  localparam int SensBaseSh = 15;
  localparam int RefSh      = 8;
  localparam int T2Sh       = 31;
  localparam int PresSh     = 15;

  localparam int TempBase = 2000;  // 20.00 C
  localparam int ColdOff  = 3500;  // -15.00 C relative to 20.00 C

  localparam int PipeDepth = 9;

  typedef enum logic [2:0] {
    REG_SENS      = 3'd0,
    REG_OFF       = 3'd1,
    REG_SENS_TC   = 3'd2,
    REG_OFF_TC    = 3'd3,
    REG_TREF      = 3'd4,
    REG_TEMP_SENS = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } cmd_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp_centi;
    logic signed [PresW-1:0] pressure_out;
    logic                    low_temp_applied;
  } res_t;

endpackage

`default_nettype wire

### sv/baro_pressure_temp_compensation.sv
// ============================================================================
// baro_pressure_temp_compensation
// Second-order compensation of raw pressure/temperature conversions.
// ============================================================================
// A word of two raw 24-bit conversions enters on cmd_i when start is high;
// busy never rises, so one word can enter on every clock. Its result appears
// on res_o with done_o high for exactly one cycle, once it has passed the
// nine register stages below (s1 to s8 and the output register), the first
// of which loads at the edge that took it in. The receiver cannot stall the
// pipeline. The six calibration words sit in APB registers at byte addresses
// 0x00..0x14 and are read by the dT, product and first-order stages, so
// write them only while no word is in flight.
// ============================================================================
`default_nettype none

`include "baro_pressure_temp_compensation_macros.svh"

module baro_pressure_temp_compensation
  import bptc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // command side
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd_i,
  // result side
  output logic             done_o,
  output res_t             res_o,
  // APB
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // --------------------------------------------------------------------------
  // Calibration registers
  // --------------------------------------------------------------------------
  logic [CoefW-1:0] sens_coeff_q, off_coeff_q, sens_temp_coeff_q;
  logic [CoefW-1:0] off_temp_coeff_q, ref_temp_coeff_q, temp_sens_coeff_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;  // fully pipelined, never blocks
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:AddrLsb]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_coeff_q      <= '0;
      off_coeff_q       <= '0;
      sens_temp_coeff_q <= '0;
      off_temp_coeff_q  <= '0;
      ref_temp_coeff_q  <= '0;
      temp_sens_coeff_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SENS:      sens_coeff_q      <= pwdata[CoefW-1:0];
        REG_OFF:       off_coeff_q       <= pwdata[CoefW-1:0];
        REG_SENS_TC:   sens_temp_coeff_q <= pwdata[CoefW-1:0];
        REG_OFF_TC:    off_temp_coeff_q  <= pwdata[CoefW-1:0];
        REG_TREF:      ref_temp_coeff_q  <= pwdata[CoefW-1:0];
        REG_TEMP_SENS: temp_sens_coeff_q <= pwdata[CoefW-1:0];
        default: ;  // unmapped addresses ignore writes
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_SENS:      prdata = DataW'(sens_coeff_q);
      REG_OFF:       prdata = DataW'(off_coeff_q);
      REG_SENS_TC:   prdata = DataW'(sens_temp_coeff_q);
      REG_OFF_TC:    prdata = DataW'(off_temp_coeff_q);
      REG_TREF:      prdata = DataW'(ref_temp_coeff_q);
      REG_TEMP_SENS: prdata = DataW'(temp_sens_coeff_q);
      default:       prdata = '0;
    endcase
  end

  // coefficients as signed operands
  logic signed [CoefSW-1:0] c3_s, c4_s, c6_s;
  assign c3_s = $signed({1'b0, sens_temp_coeff_q});
  assign c4_s = $signed({1'b0, off_temp_coeff_q});
  assign c6_s = $signed({1'b0, temp_sens_coeff_q});

  // --------------------------------------------------------------------------
  // Valid chain: bit k marks stage k+1 as holding a word
  // --------------------------------------------------------------------------
  logic [PipeDepth-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeDepth-2:0], start};
    end
  end

  assign done_o = vld_q[PipeDepth-1];

  // --------------------------------------------------------------------------
  // Stage 1: dT = D2 - C5 * 2^8
  // --------------------------------------------------------------------------
  logic [RawW-1:0]       s1_d1_q;
  logic signed [DtW-1:0] s1_dt_q, s1_dt_d;

  assign s1_dt_d = $signed({1'b0, cmd_i.raw_temperature})
                 - $signed({1'b0, ref_temp_coeff_q, {RefSh{1'b0}}});

  // --------------------------------------------------------------------------
  // Stage 2: the three dT products and dT^2
  // --------------------------------------------------------------------------
  logic [RawW-1:0]         s2_d1_q;
  logic signed [ProdW-1:0] s2_pt_q, s2_poff_q, s2_psens_q;
  logic signed [ProdW-1:0] s2_pt_d, s2_poff_d, s2_psens_d;
  logic signed [DdW-1:0]   s2_pdd_q, s2_pdd_d;

  assign s2_pt_d    = ProdW'(s1_dt_q) * ProdW'(c6_s);
  assign s2_poff_d  = ProdW'(s1_dt_q) * ProdW'(c4_s);
  assign s2_psens_d = ProdW'(s1_dt_q) * ProdW'(c3_s);
  assign s2_pdd_d   = DdW'(s1_dt_q) * DdW'(s1_dt_q);

  // --------------------------------------------------------------------------
  // Stage 3: first-order TEMP, OFF, SENS; T2 (dT^2 is never negative)
  // --------------------------------------------------------------------------
  logic [RawW-1:0]          s3_d1_q;
  logic signed [DevW-1:0]   s3_dev_q, s3_dev_d;
  logic signed [TempW-1:0]  s3_temp_q, s3_temp_d;
  logic signed [OffW-1:0]   s3_off_q, s3_off_d, s3_sens_q, s3_sens_d;
  logic [T2W-1:0]           s3_t2_q;

  assign s3_dev_d  = $signed(s2_pt_q[ProdW-1:TempSh]);
  assign s3_temp_d = TempW'(s3_dev_d) + TempW'(TempBase);
  assign s3_off_d  = $signed(OffW'({off_coeff_q, {OffBaseSh{1'b0}}}))
                   + OffW'($signed(s2_poff_q[ProdW-1:OffSh]));
  assign s3_sens_d = $signed(OffW'({sens_coeff_q, {SensBaseSh{1'b0}}}))
                   + OffW'($signed(s2_psens_q[ProdW-1:SensSh]));

  // --------------------------------------------------------------------------
  // Stage 4: squared deviations from 20.00 C and -15.00 C
  // --------------------------------------------------------------------------
  logic [RawW-1:0]         s4_d1_q;
  logic signed [TempW-1:0] s4_temp_q;
  logic signed [OffW-1:0]  s4_off_q, s4_sens_q;
  logic [T2W-1:0]          s4_t2_q;
  logic [SqW-1:0]          s4_sq_q, s4_dsq_q;
  logic                    s4_low_q, s4_vlow_q;
  logic signed [TempW-1:0] s4_dv2_d;
  logic signed [2*DevW-1:0]  s4_sq_full;
  logic signed [2*TempW-1:0] s4_dsq_full;

  assign s4_dv2_d    = TempW'(s3_dev_q) + TempW'(ColdOff);
  assign s4_sq_full  = (2*DevW)'(s3_dev_q) * (2*DevW)'(s3_dev_q);
  assign s4_dsq_full = (2*TempW)'(s4_dv2_d) * (2*TempW)'(s4_dv2_d);

  // --------------------------------------------------------------------------
  // Stage 5: OFF2, SENS2 (zero above 20.00 C)
  // --------------------------------------------------------------------------
  logic [RawW-1:0]         s5_d1_q;
  logic signed [TempW-1:0] s5_temp_q;
  logic signed [OffW-1:0]  s5_off_q, s5_sens_q;
  logic [T2W-1:0]          s5_t2_q;
  logic [CorrW-1:0]        s5_off2_q, s5_sens2_q, s5_off2_d, s5_sens2_d;
  logic                    s5_low_q;
  logic [CorrW-1:0]        five_sq, seven_dsq, eleven_dsq, cold_off, cold_sens;

  assign five_sq    = CorrW'(s4_sq_q) + CorrW'({s4_sq_q, 2'b00});
  assign seven_dsq  = CorrW'({s4_dsq_q, 3'b000}) - CorrW'(s4_dsq_q);
  assign eleven_dsq = CorrW'({s4_dsq_q, 3'b000}) + CorrW'({s4_dsq_q, 1'b0})
                    + CorrW'(s4_dsq_q);
  assign cold_off   = s4_vlow_q ? seven_dsq : '0;
  assign cold_sens  = s4_vlow_q ? (eleven_dsq >> 1) : '0;
  assign s5_off2_d  = s4_low_q ? (five_sq >> 1) + cold_off  : '0;
  assign s5_sens2_d = s4_low_q ? (five_sq >> 2) + cold_sens : '0;

  // --------------------------------------------------------------------------
  // Stage 6: final TEMP, OFF, SENS
  // --------------------------------------------------------------------------
  logic [RawW-1:0]         s6_d1_q;
  logic signed [TempW-1:0] s6_temp_q, s6_temp_d;
  logic signed [OffW-1:0]  s6_off_q, s6_sens_q, s6_off_d, s6_sens_d;
  logic                    s6_low_q;

  assign s6_temp_d = s5_temp_q - (s5_low_q ? $signed(TempW'(s5_t2_q)) : '0);
  assign s6_off_d  = s5_off_q  - $signed(OffW'(s5_off2_q));
  assign s6_sens_d = s5_sens_q - $signed(OffW'(s5_sens2_q));

  // --------------------------------------------------------------------------
  // Stage 7: D1 * SENS as two partial products (SENS split at bit 21)
  // --------------------------------------------------------------------------
  logic signed [TempW-1:0] s7_temp_q;
  logic signed [OffW-1:0]  s7_off_q;
  logic                    s7_low_q;
  logic signed [PpW-1:0]   s7_pph_q, s7_pph_d;
  logic [PplW-1:0]         s7_ppl_q, s7_ppl_d;
  logic signed [SplitW-1:0] sens_hi;

  assign sens_hi  = $signed(s6_sens_q[OffW-1:SplitW]);
  assign s7_pph_d = PpW'($signed({1'b0, s6_d1_q})) * PpW'(sens_hi);
  assign s7_ppl_d = PplW'(s6_d1_q) * PplW'(s6_sens_q[SplitW-1:0]);

  // --------------------------------------------------------------------------
  // Stage 8: P = ((D1*SENS >> 21) - OFF) >> 15; low product is non-negative,
  // so its floor shift folds into the high product exactly
  // --------------------------------------------------------------------------
  logic signed [TempW-1:0] s8_temp_q;
  logic                    s8_low_q;
  logic signed [PshW-1:0]  s8_p_q;
  logic signed [SumW-1:0]  p_sum;

  assign p_sum = SumW'(s7_pph_q)
               + $signed(SumW'(s7_ppl_q[PplW-1:SplitW]))
               - SumW'(s7_off_q);

  // --------------------------------------------------------------------------
  // Stage 9: saturate to 32 bits, output register
  // --------------------------------------------------------------------------
  res_t res_q, res_d;

  always_comb begin
    res_d.temp_centi       = s8_temp_q;
    res_d.low_temp_applied = s8_low_q;
    if (s8_p_q[PshW-1] != s8_p_q[PresW-1]) begin
      res_d.pressure_out = s8_p_q[PshW-1] ? {1'b1, {(PresW-1){1'b0}}}
                                          : {1'b0, {(PresW-1){1'b1}}};
    end else begin
      res_d.pressure_out = s8_p_q[PresW-1:0];
    end
  end

  assign res_o = res_q;

  // --------------------------------------------------------------------------
  // Datapath registers (no reset, qualified by vld_q)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    s1_d1_q    <= cmd_i.raw_pressure;
    s1_dt_q    <= s1_dt_d;

    s2_d1_q    <= s1_d1_q;
    s2_pt_q    <= s2_pt_d;
    s2_poff_q  <= s2_poff_d;
    s2_psens_q <= s2_psens_d;
    s2_pdd_q   <= s2_pdd_d;

    s3_d1_q    <= s2_d1_q;
    s3_dev_q   <= s3_dev_d;
    s3_temp_q  <= s3_temp_d;
    s3_off_q   <= s3_off_d;
    s3_sens_q  <= s3_sens_d;
    s3_t2_q    <= s2_pdd_q[T2Sh+T2W-1:T2Sh];

    s4_d1_q    <= s3_d1_q;
    s4_temp_q  <= s3_temp_q;
    s4_off_q   <= s3_off_q;
    s4_sens_q  <= s3_sens_q;
    s4_t2_q    <= s3_t2_q;
    s4_sq_q    <= s4_sq_full[SqW-1:0];
    s4_dsq_q   <= s4_dsq_full[SqW-1:0];
    s4_low_q   <= s3_dev_q[DevW-1];   // TEMP below 20.00 C
    s4_vlow_q  <= s4_dv2_d[TempW-1];  // TEMP below -15.00 C

    s5_d1_q    <= s4_d1_q;
    s5_temp_q  <= s4_temp_q;
    s5_off_q   <= s4_off_q;
    s5_sens_q  <= s4_sens_q;
    s5_t2_q    <= s4_t2_q;
    s5_off2_q  <= s5_off2_d;
    s5_sens2_q <= s5_sens2_d;
    s5_low_q   <= s4_low_q;

    s6_d1_q    <= s5_d1_q;
    s6_temp_q  <= s6_temp_d;
    s6_off_q   <= s6_off_d;
    s6_sens_q  <= s6_sens_d;
    s6_low_q   <= s5_low_q;

    s7_temp_q  <= s6_temp_q;
    s7_off_q   <= s6_off_q;
    s7_low_q   <= s6_low_q;
    s7_pph_q   <= s7_pph_d;
    s7_ppl_q   <= s7_ppl_d;

    s8_temp_q  <= s7_temp_q;
    s8_low_q   <= s7_low_q;
    s8_p_q     <= p_sum[SumW-1:PresSh];

    res_q      <= res_d;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BPTC_ASSERT_IMP(a_done_latency, done_o, $past(start, PipeDepth),
                   "done_o without a word taken PipeDepth cycles earlier")
  `BPTC_ASSERT_IMP(a_low_flag, done_o,
                   res_o.low_temp_applied == (res_o.temp_centi < TempBase),
                   "low_temp_applied disagrees with temp_centi")
  `BPTC_ASSERT_IMP(a_cold_in_low, vld_q[3] && s4_vlow_q, s4_low_q,
                   "cold correction flagged without low-temperature branch")
  `BPTC_ASSERT_NXT(a_corr_masked, vld_q[3] && !s4_low_q,
                   s5_off2_q == '0 && s5_sens2_q == '0,
                   "second-order terms not cleared above 20.00 C")

endmodule

`default_nettype wire

### sim/baro_pressure_temp_compensation_check.sv
`timescale 1ns / 100ps
// ============================================================================
// baro_pressure_temp_compensation_check
// Watches the command, result and APB channels of the compensation block,
// keeps its own calibration copy, predicts every reading and compares.
// ============================================================================

module baro_pressure_temp_compensation_check
  import bptc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  cmd_t             cmd_i,
  input  logic             done_i,
  input  res_t             res_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  input  logic [DataW-1:0] prdata_i,
  input  logic             pready_i,
  output int               errors_o,
  output int               pending_o,
  output int               words_o,
  output int               low_o,
  output int               cold_o
);

  localparam int     NumCal     = 6;
  localparam int     MaxReports = 10;
  localparam longint TRef       = 2000;   // 20.00 C
  localparam longint TCold      = -1500;  // -15.00 C
  localparam longint PMax       = 64'sd2147483647;
  localparam longint PMin       = -64'sd2147483648;

  logic [CoefW-1:0] cal_q [NumCal];
  res_t             expected_readings [$];

  // second-order compensation of one raw pair with the current calibration
  function automatic res_t compensate(input cmd_t w, output bit cold);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, dev, t2, off2, sens2, dv2, p;
    res_t   r;
    d1 = w.raw_pressure;
    d2 = w.raw_temperature;
    c1 = cal_q[REG_SENS];
    c2 = cal_q[REG_OFF];
    c3 = cal_q[REG_SENS_TC];
    c4 = cal_q[REG_OFF_TC];
    c5 = cal_q[REG_TREF];
    c6 = cal_q[REG_TEMP_SENS];
    cold = 1'b0;
    r.low_temp_applied = 1'b0;

    dt   = d2 - (c5 <<< 8);
    temp = TRef + ((dt * c6) >>> 23);
    off  = (c2 <<< 16) + ((c4 * dt) >>> 7);
    sens = (c1 <<< 15) + ((c3 * dt) >>> 8);

    if (temp < TRef) begin
      dev   = temp - TRef;
      t2    = (dt * dt) >>> 31;
      off2  = (5 * dev * dev) >>> 1;
      sens2 = (5 * dev * dev) >>> 2;
      if (temp < TCold) begin
        dv2   = temp - TCold;
        off2  = off2 + 7 * dv2 * dv2;
        sens2 = sens2 + ((11 * dv2 * dv2) >>> 1);
        cold  = 1'b1;
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;
      r.low_temp_applied = 1'b1;
    end

    p = (((d1 * sens) >>> 21) - off) >>> 15;
    if (p > PMax) p = PMax;
    if (p < PMin) p = PMin;

    r.temp_centi   = temp[TempW-1:0];
    r.pressure_out = p[PresW-1:0];
    return r;
  endfunction

  task automatic flag(input string what);
    errors_o++;
    if (errors_o <= MaxReports) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin
    res_t       want;
    bit         cold;
    logic [2:0] idx;
    idx = paddr_i[AddrLsb +: 3];
    if (!rst_ni) begin
      foreach (cal_q[i]) cal_q[i] = '0;
      expected_readings.delete();
    end else begin
      // predict before any register update at this edge
      if (start_i && !busy_i) begin
        want = compensate(cmd_i, cold);
        expected_readings.push_back(want);
        words_o++;
        if (want.low_temp_applied) low_o++;
        if (cold) cold_o++;
      end

      if (done_i) begin
        if (expected_readings.size() == 0) begin
          flag($sformatf("unexpected reading temp %0d pressure %0d low %0b",
                         res_i.temp_centi, res_i.pressure_out, res_i.low_temp_applied));
        end else begin
          want = expected_readings.pop_front();
          if (res_i.temp_centi !== want.temp_centi ||
              res_i.pressure_out !== want.pressure_out ||
              res_i.low_temp_applied !== want.low_temp_applied) begin
            flag($sformatf({"reading mismatch (exp/got): temp %0d/%0d ",
                            "pressure %0d/%0d low %0b/%0b"},
                           want.temp_centi, res_i.temp_centi,
                           want.pressure_out, res_i.pressure_out,
                           want.low_temp_applied, res_i.low_temp_applied));
          end
        end
      end

      if (psel_i && penable_i && pready_i && idx < NumCal) begin
        if (pwrite_i) begin
          cal_q[idx] = pwdata_i[CoefW-1:0];
        end else if (prdata_i !== DataW'(cal_q[idx])) begin
          flag($sformatf("readback of reg %0d: exp %h got %h",
                         idx, cal_q[idx], prdata_i));
        end
      end
    end
    pending_o = expected_readings.size();
  end

endmodule

### sim/baro_pressure_temp_compensation_test.sv
`timescale 1ns / 100ps
// ============================================================================
// baro_pressure_temp_compensation_test
// Drives raw conversion pairs and calibration sets into the compensation
// block; the checker beside it predicts and scores every reading.
// ============================================================================

module baro_pressure_temp_compensation_test;
  import bptc_pkg::*;

  localparam int         NumRegs     = 6;
  localparam logic [2:0] UnmappedLo  = 3'd6;   // first index past the map
  localparam logic [2:0] UnmappedHi  = 3'd7;
  localparam int         ItemsPerSet = 70;
  localparam int         NumSets     = 7;
  localparam int         StallLimit  = 2000;   // quiet cycles before giving up

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  cmd_t             cmd;
  logic             done;
  res_t             res;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int errors, pending, words, lows, colds;

  // stimulus state
  bit               idle_on;
  int               cal_sets;
  logic [CoefW-1:0] tref_now;    // tracks what was loaded, used to aim temps
  logic [CoefW-1:0] tsens_now;

  baro_pressure_temp_compensation dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd),
    .done_o  (done),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  baro_pressure_temp_compensation_check checker_u (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_i    (busy),
    .cmd_i     (cmd),
    .done_i    (done),
    .res_i     (res),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_i  (prdata),
    .pready_i  (pready),
    .errors_o  (errors),
    .pending_o (pending),
    .words_o   (words),
    .low_o     (lows),
    .cold_o    (colds)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Watchdog: any accepted word, reading or APB access resets the count.
  // --------------------------------------------------------------------------
  int quiet;
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done || (psel && penable)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= StallLimit) begin
        $display("watchdog: no traffic for %0d cycles, %0d readings outstanding",
                 quiet, pending);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Helpers. All of them are entered and left right after a rising edge.
  // --------------------------------------------------------------------------
  function automatic logic [AddrW-1:0] reg_addr(input logic [2:0] idx);
    return AddrW'(idx) << AddrLsb;
  endfunction

  // One APB transfer: setup, access, then bus idle so back-to-back
  // calls never lower and raise psel in the same step.
  task automatic apb_xfer(input bit wr, input logic [AddrW-1:0] addr,
                          input logic [CoefW-1:0] val);
    logic [CoefW-1:0] junk;
    junk = CoefW'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= {junk, val};   // upper half is junk; only the low 16 bits stick
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Full calibration load, a poke at both unmapped slots, then readback.
  task automatic load_cal(input logic [CoefW-1:0] c_sens, c_off, c_sens_tc,
                          c_off_tc, c_tref, c_tsens);
    apb_xfer(1'b1, reg_addr(REG_SENS),      c_sens);
    apb_xfer(1'b1, reg_addr(REG_OFF),       c_off);
    apb_xfer(1'b1, reg_addr(REG_SENS_TC),   c_sens_tc);
    apb_xfer(1'b1, reg_addr(REG_OFF_TC),    c_off_tc);
    apb_xfer(1'b1, reg_addr(REG_TREF),      c_tref);
    apb_xfer(1'b1, reg_addr(REG_TEMP_SENS), c_tsens);
    // writes past the map must not alias onto a real register
    apb_xfer(1'b1, reg_addr(UnmappedLo), CoefW'($urandom));
    apb_xfer(1'b1, reg_addr(UnmappedHi), CoefW'($urandom));
    for (int i = 0; i < NumRegs; i++) apb_xfer(1'b0, reg_addr(3'(i)), '0);
    tref_now  = c_tref;
    tsens_now = c_tsens;
    cal_sets++;
  endtask

  // Offer one word; with idling on, sometimes drop start first.
  // Returns on the edge that took the word.
  task automatic send_word(input logic [RawW-1:0] p, input logic [RawW-1:0] t);
    if (idle_on && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start              <= 1'b1;
    cmd.raw_pressure    <= p;
    cmd.raw_temperature <= t;
    do @(posedge clk_i); while (busy);
  endtask

  // Stop offering and wait until every expected reading has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Raw temperature whose first-order TEMP lands exactly on target
  // (ceiling division so the floor shift in the block hits it).
  function automatic logic [RawW-1:0] d2_for_temp(input longint target);
    longint ts, num, dt, d2;
    ts = tsens_now;
    if (ts == 0) return RawW'($urandom);
    num = (target - 2000) * 64'sd8388608;
    if (num < 0) dt = -((-num) / ts);
    else         dt = (num + ts - 1) / ts;
    d2 = (longint'(tref_now) <<< 8) + dt;
    if (d2 < 0) d2 = 0;
    if (d2 > 64'sd16777215) d2 = 64'sd16777215;
    return d2[RawW-1:0];
  endfunction

  // Mostly full-range pairs, a share aimed between -40 C and 20 C (across the
  // -15 C threshold), and some all-zero / all-one fields.
  function automatic cmd_t random_cmd();
    cmd_t w;
    int   pick;
    w.raw_pressure    = RawW'($urandom);
    w.raw_temperature = RawW'($urandom);
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: begin
        w.raw_temperature = d2_for_temp(int'($urandom_range(0, 6000)) - 4000);
      end
      2: begin
        w.raw_pressure    = $urandom_range(0, 1) ? '1 : '0;
        w.raw_temperature = $urandom_range(0, 1) ? '1 : '0;
      end
      default: ;
    endcase
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    cmd_t w;
    start   <= 1'b0;
    cmd     <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni  <= 1'b0;
    idle_on  = 1'b1;
    cal_sets = 0;
    tref_now  = '0;
    tsens_now = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Uncalibrated: registers still at reset, block must compute regardless.
    send_word('0, '0);
    send_word('1, '1);
    send_word(RawW'($urandom), RawW'($urandom));
    drain();

    // Typical factory calibration, directed corners.
    load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    send_word('0, '0);                         // deep cold, zero pressure
    send_word('1, '1);                         // hottest, full-scale pressure
    send_word('1, '0);
    send_word('0, '1);
    send_word(24'd9085466, 24'd8569150);       // ordinary room reading
    send_word(24'hAAAAAA, 24'h555555);
    send_word(24'h555555, 24'hAAAAAA);
    send_word(24'd9085466, {tref_now, 8'h00}); // zero temperature difference
    send_word(24'd9085466, d2_for_temp(2000)); // right at 20.00 C: no correction
    send_word(24'd9085466, d2_for_temp(1999)); // just below: second order on
    send_word(24'd9085466, d2_for_temp(-1500)); // at -15.00 C: no cold term
    send_word(24'd9085466, d2_for_temp(-1501)); // just below: cold term on
    drain();

    // All coefficients at full scale.
    load_cal('1, '1, '1, '1, '1, '1);
    send_word('0, '0);
    send_word('1, '1);
    send_word('1, '0);
    send_word('0, '1);
    drain();

    // Random stream over several calibration sets. Set 1 runs without any
    // idling; set 3 also pauses mid-stream until the pipe is empty.
    for (int s = 0; s < NumSets; s++) begin
      case (s)
        0: load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        1: load_cal('1, '1, '1, '1, '1, '1);
        2: load_cal('0, '0, '0, '0, '0, '0);
        5: load_cal(CoefW'($urandom), CoefW'($urandom), CoefW'($urandom),
                    CoefW'($urandom), '0, '1);   // reference at zero: mostly hot
        6: load_cal(CoefW'($urandom), CoefW'($urandom), CoefW'($urandom),
                    CoefW'($urandom), '1, '1);   // reference at top: mostly cold
        default: load_cal(CoefW'($urandom), CoefW'($urandom), CoefW'($urandom),
                          CoefW'($urandom), CoefW'($urandom), CoefW'($urandom));
      endcase
      idle_on = (s != 1);
      for (int k = 0; k < ItemsPerSet; k++) begin
        if (s == 3 && k == ItemsPerSet / 2) drain();
        w = random_cmd();
        send_word(w.raw_pressure, w.raw_temperature);
      end
      drain();
    end

    // let the nine-stage pipe settle in case anything stray comes out
    repeat (PipeDepth + 4) @(posedge clk_i);

    $display("Ran %0d words over %0d calibration sets: %0d below 20 C, %0d below -15 C.",
             words, cal_sets, lows, colds);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d readings never arrived", errors, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/bptc_pkg.sv
sv/baro_pressure_temp_compensation.sv
sim/baro_pressure_temp_compensation_check.sv
sim/baro_pressure_temp_compensation_test.sv
